>>> rtl/radar_phase_kernel_exp_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef RADAR_PHASE_KERNEL_EXP_ASSERT_SVH
`define RADAR_PHASE_KERNEL_EXP_ASSERT_SVH
`ifndef SYNTHESIS
`define RPK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpk assertion failed");
`define RPK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpk assertion failed");
`else
`define RPK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/rpk_pkg.sv
package rpk_pkg;

	localparam int GRID_W   = 13;
	localparam int INV_W    = 25;
	localparam int SCALED_W = 30;
	localparam int Q_W      = 62;
	localparam int R_W      = 31;
	localparam int W_W      = 32;
	localparam int PROD_W   = 63;
	localparam int PI_W     = 47;
	localparam int CST_W    = GRID_W + PI_W;
	localparam int ANG_W    = 32;
	localparam int XY_W     = 34;
	localparam int MAX_STAGES = 24;

	localparam logic [GRID_W-1:0]   GRID_RESET = 13'd256;
	localparam logic [INV_W-1:0]    INV_RESET  = 25'd65536;
	localparam logic [SCALED_W-1:0] SCALED_MAX = 30'h3FFF_FFFF;
	localparam logic [PI_W-1:0]     INV_PI_Q48 = 47'h517C_C1B7_2722;
	localparam logic [ANG_W-1:0]    CORDIC_K   = 32'h26DD_3B6A;

	typedef enum logic {
		REG_GRID_SIZE     = 1'b0,
		REG_INV_GRID_SIZE = 1'b1
	} rpk_reg_t;

	typedef struct packed {
		logic [Q_W-1:0] q;
		logic [W_W-1:0] w;
	} rpk_root_req_t;

	typedef struct packed {
		logic [R_W-1:0] r;
		logic [W_W-1:0] w;
	} rpk_root_rsp_t;

	typedef struct packed {
		logic signed [XY_W-1:0] c;
		logic signed [XY_W-1:0] s;
	} rpk_trig_t;

	// arctan(2^-i) in turns, Q0.32
	function automatic logic [ANG_W-1:0] atan_turn(input int unsigned idx);
		logic [ANG_W-1:0] a;
		case (idx)
			0:  a = 32'h2000_0000;
			1:  a = 32'h12E4_051E;
			2:  a = 32'h09FB_385B;
			3:  a = 32'h0511_11D4;
			4:  a = 32'h028B_0D43;
			5:  a = 32'h0145_D7E1;
			6:  a = 32'h00A2_F61E;
			7:  a = 32'h0051_7C55;
			8:  a = 32'h0028_BE53;
			9:  a = 32'h0014_5F2F;
			10: a = 32'h000A_2F98;
			11: a = 32'h0005_17CC;
			12: a = 32'h0002_8BE6;
			13: a = 32'h0001_45F3;
			14: a = 32'h0000_A2FA;
			15: a = 32'h0000_517D;
			16: a = 32'h0000_28BE;
			17: a = 32'h0000_145F;
			18: a = 32'h0000_0A30;
			19: a = 32'h0000_0518;
			20: a = 32'h0000_028C;
			21: a = 32'h0000_0146;
			22: a = 32'h0000_00A3;
			default: a = 32'h0000_0051;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/rpk_scale.sv
module rpk_scale
	import rpk_pkg::*;
#(
	parameter int COORD_WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [4*COORD_WIDTH-1:0] in_data,
	input  logic [INV_W-1:0]         inv_grid_size,
	output logic                     out_valid,
	output rpk_root_req_t            out_data
);

	localparam int PW   = COORD_WIDTH + INV_W;
	localparam int SQ_W = 2 * SCALED_W;

	logic [PW-1:0]       p_s1 [4];
	logic [SCALED_W-1:0] c_s2 [4];
	logic [SCALED_W-1:0] ad_s3, x2_s3;
	logic [W_W-1:0]      w_s3, w_s4, w_s5;
	logic [SQ_W-1:0]     sqa_s4, sqb_s4;
	logic [Q_W-1:0]      q_s5;
	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		logic [PW:0]    rnd;
		logic [PW-16:0] shf;

		assign rnd = {1'b0, p_s1[g]} + (PW+1)'(32'h8000);
		assign shf = rnd[PW:16];

		always_ff @(posedge clk) begin
			if (en) begin
				p_s1[g] <= PW'(in_data[g*COORD_WIDTH +: COORD_WIDTH]) * PW'(inv_grid_size);
				c_s2[g] <= (64'(shf) > 64'(SCALED_MAX)) ? SCALED_MAX : SCALED_W'(shf);
			end
		end
	end

	// lanes: 0 target_x, 1 target_y, 2 source_freq, 3 source_offset
	always_ff @(posedge clk) begin
		if (en) begin
			ad_s3  <= (c_s2[3] >= c_s2[0]) ? c_s2[3] - c_s2[0] : c_s2[0] - c_s2[3];
			x2_s3  <= c_s2[1];
			w_s3   <= W_W'(32'h1_0000) + {2'b0, c_s2[2]} + {1'b0, c_s2[2], 1'b0};
			sqa_s4 <= SQ_W'(ad_s3) * SQ_W'(ad_s3);
			sqb_s4 <= SQ_W'(x2_s3) * SQ_W'(x2_s3);
			w_s4   <= w_s3;
			q_s5   <= Q_W'(sqa_s4) + Q_W'(sqb_s4) + Q_W'(64'h1_0000_0000);
			w_s5   <= w_s4;
		end
	end

	assign out_valid  = vld_s5;
	assign out_data.q = q_s5;
	assign out_data.w = w_s5;

endmodule

>>> rtl/rpk_sqrt.sv
module rpk_sqrt
	import rpk_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  rpk_root_req_t in_data,
	output logic          out_valid,
	output rpk_root_rsp_t out_data
);

	localparam int RT_W = Q_W + 1;

	logic [Q_W-1:0]  rem_s  [1:R_W];
	logic [RT_W-1:0] root_s [1:R_W];
	logic [W_W-1:0]  w_s    [1:R_W];
	logic            vld_s  [1:R_W];

	for (genvar g = 0; g < R_W; g++) begin : g_step
		localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (R_W - 1 - g));

		logic [Q_W-1:0]  rem_in;
		logic [RT_W-1:0] root_in;
		logic [W_W-1:0]  w_in;
		logic            vld_in;
		logic [RT_W-1:0] trial;
		logic            take;

		if (g == 0) begin : g_head
			assign rem_in  = in_data.q;
			assign root_in = '0;
			assign w_in    = in_data.w;
			assign vld_in  = in_valid;
		end else begin : g_body
			assign rem_in  = rem_s[g];
			assign root_in = root_s[g];
			assign w_in    = w_s[g];
			assign vld_in  = vld_s[g];
		end

		assign trial = root_in + BIT;
		assign take  = RT_W'(rem_in) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? rem_in - Q_W'(trial) : rem_in;
				root_s[g+1] <= take ? (root_in >> 1) + BIT : root_in >> 1;
				w_s[g+1]    <= w_in;
			end
		end
	end

	assign out_valid  = vld_s[R_W];
	assign out_data.r = root_s[R_W][R_W-1:0];
	assign out_data.w = w_s[R_W];

endmodule

>>> rtl/rpk_phase.sv
module rpk_phase
	import rpk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  rpk_root_rsp_t    in_data,
	input  logic [CST_W-1:0] cst,
	output logic             out_valid,
	output logic [ANG_W-1:0] angle
);

	localparam int ACC_W = 80;

	logic [PROD_W-1:0] prod_s1;
	logic [63:0]       ll_s2, lh_s2, hl_s2, hh_s2;
	logic [ANG_W-1:0]  turns_s3, angle_s4;
	logic [ACC_W-1:0]  acc;
	logic              vld_s1, vld_s2, vld_s3, vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// only bits below 2^80 of the full product reach the turn count
	assign acc = ACC_W'(ll_s2) + (ACC_W'(lh_s2) << 32) + (ACC_W'(hl_s2) << 32)
		+ (ACC_W'(hh_s2) << 64);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PROD_W'(in_data.w) * PROD_W'(in_data.r);
			ll_s2    <= 64'(prod_s1[31:0]) * 64'(cst[31:0]);
			lh_s2    <= 64'(prod_s1[31:0]) * 64'(cst[CST_W-1:32]);
			hl_s2    <= 64'(prod_s1[PROD_W-1:32]) * 64'(cst[31:0]);
			hh_s2    <= 64'(prod_s1[PROD_W-1:32]) * 64'(cst[CST_W-1:32]);
			turns_s3 <= acc[79:48];
			angle_s4 <= ANG_W'(0) - turns_s3;
		end
	end

	assign out_valid = vld_s4;
	assign angle     = angle_s4;

endmodule

>>> rtl/rpk_cordic.sv
module rpk_cordic
	import rpk_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [ANG_W-1:0] angle,
	output logic             out_valid,
	output rpk_trig_t        out_data
);

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	logic signed [XY_W-1:0]  x_s [1:CORDIC_STAGES];
	logic signed [XY_W-1:0]  y_s [1:CORDIC_STAGES];
	logic signed [ANG_W-1:0] z_s [1:CORDIC_STAGES];
	quad_t                   q_s [1:CORDIC_STAGES];
	logic                    vld_s [1:CORDIC_STAGES];
	rpk_trig_t               res_q;
	logic                    res_vld_q;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		logic signed [XY_W-1:0]  xi, yi, xsh, ysh;
		logic signed [ANG_W-1:0] zi, at;
		quad_t                   qi;
		logic                    vi;

		if (g == 0) begin : g_head
			assign xi = XY_W'(CORDIC_K);
			assign yi = '0;
			assign zi = {2'b00, angle[ANG_W-3:0]};
			assign qi = quad_t'(angle[ANG_W-1:ANG_W-2]);
			assign vi = in_valid;
		end else begin : g_body
			assign xi = x_s[g];
			assign yi = y_s[g];
			assign zi = z_s[g];
			assign qi = q_s[g];
			assign vi = vld_s[g];
		end

		assign xsh = xi >>> g;
		assign ysh = yi >>> g;
		assign at  = $signed(atan_turn(g));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1] <= zi[ANG_W-1] ? xi + ysh : xi - ysh;
				y_s[g+1] <= zi[ANG_W-1] ? yi - xsh : yi + xsh;
				z_s[g+1] <= zi[ANG_W-1] ? zi + at : zi - at;
				q_s[g+1] <= qi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= vld_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STAGES])
				QUAD_I: begin
					res_q.c <= x_s[CORDIC_STAGES];
					res_q.s <= y_s[CORDIC_STAGES];
				end
				QUAD_II: begin
					res_q.c <= -y_s[CORDIC_STAGES];
					res_q.s <= x_s[CORDIC_STAGES];
				end
				QUAD_III: begin
					res_q.c <= -x_s[CORDIC_STAGES];
					res_q.s <= -y_s[CORDIC_STAGES];
				end
				default: begin
					res_q.c <= y_s[CORDIC_STAGES];
					res_q.s <= -x_s[CORDIC_STAGES];
				end
			endcase
		end
	end

	assign out_valid = res_vld_q;
	assign out_data  = res_q;

endmodule

>>> rtl/radar_phase_kernel_exp.sv
// Phase kernel: for each pair of points the block returns cos and sin of
// -2*N*(1+3*k1)*sqrt((k2-x1)^2 + x2^2 + 1), with all coordinates scaled by the
// loaded reciprocal of N. It takes one point pair per clock while the output is
// not held, and returns one result per pair, in order. The pipeline runs through
// scaling and squaring, the square root (one root bit per stage), the phase
// product, CORDIC_STAGES rotations, the quadrant folding register, and
// the output register. When the output is held the whole pipeline holds with
// it. Write grid_size and inv_grid_size only while no pair is in flight.
`include "radar_phase_kernel_exp_assert.svh"

module radar_phase_kernel_exp
	import rpk_pkg::*;
#(
	parameter int COORD_WIDTH   = 20,
	parameter int OUT_WIDTH     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// target_x, target_y, source_freq, source_offset (lowest bits first)
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cos_out, sin_out (lowest bits first)
	output logic [((2*OUT_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SH = 31 - OUT_WIDTH;
	localparam logic signed [XY_W:0] HALF = (XY_W+1)'(1) << (SH - 1);
	localparam logic signed [XY_W:0] MAXV = (XY_W+1)'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
	localparam logic signed [XY_W:0] MINV = -MAXV - (XY_W+1)'(1);

	logic [GRID_W-1:0]    grid_size_q;
	logic [INV_W-1:0]     inv_grid_size_q;
	logic [CST_W-1:0]     cst_q;
	logic                 en;
	logic                 sc_valid, sq_valid, ph_valid, cor_valid;
	rpk_root_req_t        sc_data;
	rpk_root_rsp_t        sq_data;
	logic [ANG_W-1:0]     ph_angle;
	rpk_trig_t            cor_data;
	logic                 m_valid_q;
	logic [OUT_WIDTH-1:0] cos_q, sin_q;

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [XY_W-1:0] v);
		logic signed [XY_W:0] t;
		t = $signed({v[XY_W-1], v}) + HALF;
		t = t >>> SH;
		if (t > MAXV) begin
			t = MAXV;
		end else if (t < MINV) begin
			t = MINV;
		end
		return t[OUT_WIDTH-1:0];
	endfunction

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q     <= GRID_RESET;
			inv_grid_size_q <= INV_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (rpk_reg_t'(paddr[2]))
				REG_GRID_SIZE:     grid_size_q     <= pwdata[GRID_W-1:0];
				default:           inv_grid_size_q <= pwdata[INV_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (rpk_reg_t'(paddr[2]))
			REG_GRID_SIZE: prdata = 32'(grid_size_q);
			default:       prdata = 32'(inv_grid_size_q);
		endcase
	end

	always_ff @(posedge clk) begin
		cst_q <= CST_W'(grid_size_q) * CST_W'(INV_PI_Q48);
	end

	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;

	rpk_scale #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.in_data       (s_tdata[4*COORD_WIDTH-1:0]),
		.inv_grid_size (inv_grid_size_q),
		.out_valid     (sc_valid),
		.out_data      (sc_data)
	);

	rpk_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sc_valid),
		.in_data   (sc_data),
		.out_valid (sq_valid),
		.out_data  (sq_data)
	);

	rpk_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_data   (sq_data),
		.cst       (cst_q),
		.out_valid (ph_valid),
		.angle     (ph_angle)
	);

	rpk_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ph_valid),
		.angle     (ph_angle),
		.out_valid (cor_valid),
		.out_data  (cor_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= cor_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= to_out(cor_data.c);
			sin_q <= to_out(cor_data.s);
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_WIDTH-1:0] = cos_q;
		m_tdata[2*OUT_WIDTH-1:OUT_WIDTH] = sin_q;
	end

	assign m_tvalid = m_valid_q;

	`RPK_ASSERT_NXT(a_stall_holds_root, clk, arst_n, !en, $stable(sq_valid))
	`RPK_ASSERT_IMP(a_rise_needs_advance, clk, arst_n, $rose(m_tvalid), $past(en))
	`RPK_ASSERT_NXT(a_final_stage_lands, clk, arst_n, en && cor_valid, m_tvalid)

endmodule
